// ----- sv/mbq4_pkg.sv -----
// shared types, register codes and the step microcode of the biquad sequencer
package mbq4_pkg;

    typedef struct packed {
        logic [2:0]         chan;
        logic signed [23:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic [2:0]         chan_out;
    } t_out_item;

    // one channel's history word as stored in the state ram
    typedef struct packed {
        logic signed [31:0] l1;
        logic signed [31:0] l2;
        logic signed [31:0] i1;
        logic signed [31:0] i2;
        logic signed [31:0] o1;
        logic signed [31:0] o2;
    } t_hist;

    typedef enum logic [1:0] {
        MODE_DF1  = 2'd0,
        MODE_DF2  = 2'd1,
        MODE_DF1T = 2'd2,
        MODE_DF2T = 2'd3
    } t_form;

    typedef enum logic [2:0] {
        CFG_MODE = 3'd0,
        CFG_B0   = 3'd1,
        CFG_B1   = 3'd2,
        CFG_B2   = 3'd3,
        CFG_A1   = 3'd4,
        CFG_A2   = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OPA_X, OPA_W, OPA_Y, OPA_I1, OPA_I2, OPA_L1, OPA_L2, OPA_O1, OPA_O2
    } t_op_sel;

    typedef enum logic [2:0] {
        CF_B0, CF_B1, CF_B2, CF_A1, CF_A2
    } t_coef_sel;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } t_acc_op;

    typedef enum logic [2:0] {
        UP_ZERO, UP_X, UP_I1, UP_I2, UP_L1
    } t_up_sel;

    typedef enum logic [3:0] {
        FD_NONE, FD_Y, FD_W, FD_I1, FD_I2, FD_L1, FD_L2, FD_DF1, FD_DF2
    } t_fin_dst;

    typedef struct packed {
        logic      mul_en;
        t_op_sel   op_a;
        t_coef_sel coef;
        t_acc_op   acc_op;
        t_up_sel   up_sel;
        t_fin_dst  fin_dst;
        logic      w_sat;
        logic      last;
    } t_uop;

    localparam int         STEP_W       = 3;
    localparam logic [23:0] COEF_ONE    = 24'sd4194304;
    localparam int         ACC_W        = 60;
    localparam int         Q_SHIFT      = 22;

    // a product issued at a step is registered in r_prod, added into r_acc, and the sum rounded from r_acc
    function automatic t_uop get_uop(input t_form mode, input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{mul_en: 1'b0, op_a: OPA_X, coef: CF_B0, acc_op: ACC_HOLD,
              up_sel: UP_ZERO, fin_dst: FD_NONE, w_sat: 1'b0, last: 1'b0};
        unique case (mode)
            MODE_DF1: begin
                unique case (step)
                    3'd0: begin u.mul_en = 1'b1; u.op_a = OPA_X; u.coef = CF_B0; end
                    3'd1: begin
                        u.mul_en = 1'b1; u.op_a = OPA_I1; u.coef = CF_B1;
                        u.acc_op = ACC_LOAD;
                    end
                    3'd2: begin
                        u.mul_en = 1'b1; u.op_a = OPA_I2; u.coef = CF_B2;
                        u.acc_op = ACC_ADD;
                    end
                    3'd3: begin
                        u.mul_en = 1'b1; u.op_a = OPA_O1; u.coef = CF_A1;
                        u.acc_op = ACC_ADD;
                    end
                    3'd4: begin
                        u.mul_en = 1'b1; u.op_a = OPA_O2; u.coef = CF_A2;
                        u.acc_op = ACC_ADD;
                    end
                    3'd5: begin u.acc_op = ACC_ADD; end
                    3'd6: begin u.fin_dst = FD_DF1; u.last = 1'b1; end
                    default: begin u.last = 1'b1; end
                endcase
            end
            MODE_DF2: begin
                unique case (step)
                    3'd0: begin u.mul_en = 1'b1; u.op_a = OPA_L1; u.coef = CF_A1; end
                    3'd1: begin
                        u.mul_en = 1'b1; u.op_a = OPA_L2; u.coef = CF_A2;
                        u.acc_op = ACC_LOAD; u.up_sel = UP_X;
                    end
                    3'd2: begin
                        u.mul_en = 1'b1; u.op_a = OPA_L1; u.coef = CF_B1;
                        u.acc_op = ACC_ADD;
                    end
                    3'd3: begin
                        u.mul_en = 1'b1; u.op_a = OPA_L2; u.coef = CF_B2;
                        u.acc_op = ACC_LOAD; u.fin_dst = FD_W;
                    end
                    3'd4: begin
                        u.mul_en = 1'b1; u.op_a = OPA_W; u.coef = CF_B0;
                        u.acc_op = ACC_ADD;
                    end
                    3'd5: begin u.acc_op = ACC_ADD; end
                    3'd6: begin u.fin_dst = FD_DF2; u.last = 1'b1; end
                    default: begin u.last = 1'b1; end
                endcase
            end
            MODE_DF1T: begin
                unique case (step)
                    3'd0: begin u.w_sat = 1'b1; end
                    3'd1: begin u.mul_en = 1'b1; u.op_a = OPA_W; u.coef = CF_B0; end
                    3'd2: begin
                        u.mul_en = 1'b1; u.op_a = OPA_W; u.coef = CF_B1;
                        u.acc_op = ACC_LOAD; u.up_sel = UP_I2;
                    end
                    3'd3: begin
                        u.mul_en = 1'b1; u.op_a = OPA_W; u.coef = CF_A1;
                        u.acc_op = ACC_LOAD; u.up_sel = UP_I1; u.fin_dst = FD_Y;
                    end
                    3'd4: begin
                        u.mul_en = 1'b1; u.op_a = OPA_W; u.coef = CF_B2;
                        u.acc_op = ACC_LOAD; u.up_sel = UP_L1; u.fin_dst = FD_I2;
                    end
                    3'd5: begin
                        u.mul_en = 1'b1; u.op_a = OPA_W; u.coef = CF_A2;
                        u.acc_op = ACC_LOAD; u.fin_dst = FD_L2;
                    end
                    3'd6: begin u.acc_op = ACC_LOAD; u.fin_dst = FD_I1; end
                    default: begin u.fin_dst = FD_L1; u.last = 1'b1; end
                endcase
            end
            MODE_DF2T: begin
                unique case (step)
                    3'd0: begin u.mul_en = 1'b1; u.op_a = OPA_X; u.coef = CF_B0; end
                    3'd1: begin u.acc_op = ACC_LOAD; u.up_sel = UP_I2; end
                    3'd2: begin
                        u.mul_en = 1'b1; u.op_a = OPA_X; u.coef = CF_B1;
                        u.fin_dst = FD_Y;
                    end
                    3'd3: begin
                        u.mul_en = 1'b1; u.op_a = OPA_Y; u.coef = CF_A1;
                        u.acc_op = ACC_LOAD; u.up_sel = UP_I1;
                    end
                    3'd4: begin
                        u.mul_en = 1'b1; u.op_a = OPA_X; u.coef = CF_B2;
                        u.acc_op = ACC_ADD;
                    end
                    3'd5: begin
                        u.mul_en = 1'b1; u.op_a = OPA_Y; u.coef = CF_A2;
                        u.acc_op = ACC_LOAD; u.fin_dst = FD_I2;
                    end
                    3'd6: begin u.acc_op = ACC_ADD; end
                    default: begin u.fin_dst = FD_I1; u.last = 1'b1; end
                endcase
            end
        endcase
        return u;
    endfunction

endpackage

// ----- sv/mbq4_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
module mbq4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/multichannel_biquad_four_forms.sv -----
// multichannel biquad with four selectable structures, one shared multiplier
//
//  channel  direction  handshake            payload
//  in       input      i_in_valid/o_in_stall    i_in_data  (chan, sample_in)
//  out      output     o_out_valid/i_out_stall  o_out_data (sample_out, chan_out)
//  cfg      input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
// an item passes from its transfer through S_LOAD (history ram read), the microcode
// steps of S_RUN through the single 32x24 multiplier, and S_DONE (result register and
// history write-back); one item is in work at a time
// a result waiting on a stalled output holds the write-back and the input side
// synchronous reset returns control to idle, sets unity gain in transposed form ii and clears per-channel valid bits;
// a channel with no valid bit reads as zero history, so no clearing pass runs
module multichannel_biquad_four_forms #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  mbq4_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output mbq4_pkg::t_out_item   o_out_data,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [23:0]           i_cfg_data
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int HW = $bits(mbq4_pkg::t_hist);
    localparam logic [6:0] NCH = 7'(NUM_CHANNELS);
    localparam int Q_LO = mbq4_pkg::Q_SHIFT;

    typedef enum logic [1:0] {
        S_IDLE, S_LOAD, S_RUN, S_DONE
    } t_state;

    // configuration
    mbq4_pkg::t_form         r_mode;
    logic signed [23:0]      r_b0, r_b1, r_b2, r_a1, r_a2;
    logic [NUM_CHANNELS-1:0] r_valid;

    // control
    t_state                       r_state;
    logic [mbq4_pkg::STEP_W-1:0]  r_step;
    logic                         r_out_valid;
    mbq4_pkg::t_out_item          r_out_data;

    // datapath
    logic [AW-1:0]           r_addr;
    logic [2:0]              r_chan;
    logic signed [23:0]      r_x;
    logic                    r_in_range;
    mbq4_pkg::t_hist         r_h;
    logic signed [31:0]      r_w, r_y;
    logic signed [55:0]      r_prod;
    logic signed [mbq4_pkg::ACC_W-1:0] r_acc;

    logic                    in_xfer, out_free, mode_change;
    logic                    ram_we;
    logic [HW-1:0]           ram_rdata;
    logic                    hit;
    mbq4_pkg::t_uop          u;
    logic signed [31:0]      x32, op_a, up_val, fin_val, w_val;
    logic signed [23:0]      coef, y_sat24;
    logic signed [55:0]      mul_res;
    logic signed [mbq4_pkg::ACC_W-1:0] up_term, acc_t;
    logic signed [mbq4_pkg::ACC_W-Q_LO-1:0] fin_q;
    logic signed [32:0]      w_sum;

    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign ram_we      = (r_state == S_DONE) && out_free && r_in_range;
    assign mode_change = i_cfg_we && (i_cfg_idx == mbq4_pkg::CFG_MODE)
                         && (mbq4_pkg::t_form'(i_cfg_data[1:0]) != r_mode);
    assign hit         = r_in_range && r_valid[r_addr];

    mbq4_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_h),
        .i_re    (in_xfer),
        .i_raddr (AW'(i_in_data.chan)),
        .o_rdata (ram_rdata)
    );

    // configuration registers and per-channel valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= mbq4_pkg::MODE_DF2T;
            r_b0    <= mbq4_pkg::COEF_ONE;
            r_b1    <= '0;
            r_b2    <= '0;
            r_a1    <= '0;
            r_a2    <= '0;
            r_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (mbq4_pkg::t_cfg_idx'(i_cfg_idx))
                    mbq4_pkg::CFG_MODE: r_mode <= mbq4_pkg::t_form'(i_cfg_data[1:0]);
                    mbq4_pkg::CFG_B0:   r_b0 <= i_cfg_data;
                    mbq4_pkg::CFG_B1:   r_b1 <= i_cfg_data;
                    mbq4_pkg::CFG_B2:   r_b2 <= i_cfg_data;
                    mbq4_pkg::CFG_A1:   r_a1 <= i_cfg_data;
                    mbq4_pkg::CFG_A2:   r_a2 <= i_cfg_data;
                    default: begin end
                endcase
            end
            if (mode_change) begin
                r_valid <= '0;
            end else if (ram_we) begin
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    assign u   = mbq4_pkg::get_uop(r_mode, r_step);
    assign x32 = 32'(r_x);

    always_comb begin
        unique case (u.op_a)
            mbq4_pkg::OPA_X:  op_a = x32;
            mbq4_pkg::OPA_W:  op_a = r_w;
            mbq4_pkg::OPA_Y:  op_a = r_y;
            mbq4_pkg::OPA_I1: op_a = r_h.i1;
            mbq4_pkg::OPA_I2: op_a = r_h.i2;
            mbq4_pkg::OPA_L1: op_a = r_h.l1;
            mbq4_pkg::OPA_L2: op_a = r_h.l2;
            mbq4_pkg::OPA_O1: op_a = r_h.o1;
            mbq4_pkg::OPA_O2: op_a = r_h.o2;
            default:          op_a = x32;
        endcase
        unique case (u.coef)
            mbq4_pkg::CF_B0: coef = r_b0;
            mbq4_pkg::CF_B1: coef = r_b1;
            mbq4_pkg::CF_B2: coef = r_b2;
            mbq4_pkg::CF_A1: coef = r_a1;
            mbq4_pkg::CF_A2: coef = r_a2;
            default:         coef = r_b0;
        endcase
        unique case (u.up_sel)
            mbq4_pkg::UP_ZERO: up_val = '0;
            mbq4_pkg::UP_X:    up_val = x32;
            mbq4_pkg::UP_I1:   up_val = r_h.i1;
            mbq4_pkg::UP_I2:   up_val = r_h.i2;
            mbq4_pkg::UP_L1:   up_val = r_h.l1;
            default:           up_val = '0;
        endcase
    end

    assign mul_res = op_a * coef;
    // non-product term lifted to the product scale
    assign up_term = {{(mbq4_pkg::ACC_W - 32 - Q_LO){up_val[31]}}, up_val, {Q_LO{1'b0}}};

    // round half up to q9.23, then saturate to 32 bits
    assign acc_t = r_acc + (mbq4_pkg::ACC_W'(1) <<< (Q_LO - 1));
    assign fin_q = acc_t[mbq4_pkg::ACC_W-1:Q_LO];
    always_comb begin
        if (fin_q[mbq4_pkg::ACC_W-Q_LO-1:31] == '0 || fin_q[mbq4_pkg::ACC_W-Q_LO-1:31] == '1) begin
            fin_val = fin_q[31:0];
        end else if (fin_q[mbq4_pkg::ACC_W-Q_LO-1]) begin
            fin_val = 32'sh8000_0000;
        end else begin
            fin_val = 32'sh7fff_ffff;
        end
    end

    assign w_sum = 33'(x32) + 33'(r_h.l2);
    always_comb begin
        if (w_sum[32] == w_sum[31]) begin
            w_val = w_sum[31:0];
        end else if (w_sum[32]) begin
            w_val = 32'sh8000_0000;
        end else begin
            w_val = 32'sh7fff_ffff;
        end
    end

    always_comb begin
        if (!r_in_range) begin
            y_sat24 = '0;
        end else if (r_y > 32'sd8388607) begin
            y_sat24 = 24'sh7f_ffff;
        end else if (r_y < -32'sd8388608) begin
            y_sat24 = 24'sh80_0000;
        end else begin
            y_sat24 = r_y[23:0];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_chan     <= i_in_data.chan;
            r_x        <= i_in_data.sample_in;
            r_addr     <= AW'(i_in_data.chan);
            r_in_range <= (7'(i_in_data.chan) < NCH);
        end
        if (r_state == S_LOAD) begin
            r_h <= hit ? mbq4_pkg::t_hist'(ram_rdata) : '0;
        end
        if (r_state == S_RUN) begin
            if (u.mul_en) begin
                r_prod <= mul_res;
            end
            unique case (u.acc_op)
                mbq4_pkg::ACC_LOAD: r_acc <= mbq4_pkg::ACC_W'(r_prod) + up_term;
                mbq4_pkg::ACC_ADD:  r_acc <= r_acc + mbq4_pkg::ACC_W'(r_prod);
                default: begin end
            endcase
            if (u.w_sat) begin
                r_w <= w_val;
            end
            unique case (u.fin_dst)
                mbq4_pkg::FD_Y:  r_y <= fin_val;
                mbq4_pkg::FD_W:  r_w <= fin_val;
                mbq4_pkg::FD_I1: r_h.i1 <= fin_val;
                mbq4_pkg::FD_I2: r_h.i2 <= fin_val;
                mbq4_pkg::FD_L1: r_h.l1 <= fin_val;
                mbq4_pkg::FD_L2: r_h.l2 <= fin_val;
                mbq4_pkg::FD_DF1: begin
                    r_y    <= fin_val;
                    r_h.o1 <= fin_val;
                    r_h.o2 <= r_h.o1;
                    r_h.i1 <= x32;
                    r_h.i2 <= r_h.i1;
                end
                mbq4_pkg::FD_DF2: begin
                    r_y    <= fin_val;
                    r_h.l1 <= r_w;
                    r_h.l2 <= r_h.l1;
                end
                default: begin end
            endcase
        end
    end

    // sequencer state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_step  <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (u.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data.sample_out <= y_sat24;
                        r_out_data.chan_out   <= r_chan;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- sv/mbq4_chk.sv -----
// port-level checks of the biquad block and their binding to the top level
module mbq4_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input mbq4_pkg::t_out_item o_out_data
);

    // a held result stays offered until transferred
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // one item in work at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // a fresh result only comes out of a busy sequencer
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item in work");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left the block busy or a result pending");

endmodule

bind multichannel_biquad_four_forms mbq4_chk u_mbq4_chk (.*);

// ----- sim/multichannel_biquad_four_forms_test.sv -----
// self-checking testbench for the multichannel four-form biquad
`timescale 1ns / 1ps

import mbq4_pkg::*;

localparam int NUM_CH = 8;

// register indexes past the end of the map, expected to be ignored
localparam logic [2:0] CFG_SPARE_LO = 3'd6;
localparam logic [2:0] CFG_SPARE_HI = 3'd7;

class biquad_checker;
    typedef logic signed [31:0] t_word;

    t_form form;
    logic signed [23:0] b0, b1, b2, a1, a2;
    t_word loop_one[NUM_CH], loop_two[NUM_CH];
    t_word in_one[NUM_CH], in_two[NUM_CH];
    t_word out_one[NUM_CH], out_two[NUM_CH];
    t_out_item expected_outputs[$];
    int errors;

    function new();
        form   = MODE_DF2T;
        b0     = COEF_ONE;
        b1     = '0;
        b2     = '0;
        a1     = '0;
        a2     = '0;
        errors = 0;
        clear_hist();
    endfunction

    function void clear_hist();
        for (int c = 0; c < NUM_CH; c++) begin
            loop_one[c] = '0;
            loop_two[c] = '0;
            in_one[c]   = '0;
            in_two[c]   = '0;
            out_one[c]  = '0;
            out_two[c]  = '0;
        end
    endfunction

    function longint prod(t_word v, logic signed [23:0] c);
        return longint'(v) * longint'(c);
    endfunction

    function longint scaled(t_word v);
        return longint'(v) * 64'sd4194304;
    endfunction

    function t_word sat_word(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return t_word'(v);
    endfunction

    // Q.45 sum to Q9.23, round half up
    function t_word round_word(longint acc);
        return sat_word((acc + 64'sd2097152) >>> 22);
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] data);
        case (idx)
            CFG_MODE: begin
                if (t_form'(data[1:0]) != form) begin
                    form = t_form'(data[1:0]);
                    clear_hist();
                end
            end
            CFG_B0: b0 = data;
            CFG_B1: b1 = data;
            CFG_B2: b2 = data;
            CFG_A1: a1 = data;
            CFG_A2: a2 = data;
            default: ;
        endcase
    endfunction

    function void accept_sample(t_in_item it);
        t_word x, y, w, w1, w2, x1, x2;
        int c;
        t_out_item e;
        c = it.chan;
        x = {{8{it.sample_in[23]}}, it.sample_in};
        w1 = loop_one[c];
        w2 = loop_two[c];
        x1 = in_one[c];
        x2 = in_two[c];
        case (form)
            MODE_DF1: begin
                y = round_word(prod(x, b0) + prod(x1, b1) + prod(x2, b2) +
                               prod(out_one[c], a1) + prod(out_two[c], a2));
                in_two[c]  = x1;
                in_one[c]  = x;
                out_two[c] = out_one[c];
                out_one[c] = y;
            end
            MODE_DF2: begin
                w = round_word(scaled(x) + prod(w1, a1) + prod(w2, a2));
                y = round_word(prod(w, b0) + prod(w1, b1) + prod(w2, b2));
                loop_two[c] = w1;
                loop_one[c] = w;
            end
            MODE_DF1T: begin
                w = sat_word(longint'(x) + longint'(w2));
                y = round_word(prod(w, b0) + scaled(x2));
                in_two[c]   = round_word(prod(w, b1) + scaled(x1));
                loop_two[c] = round_word(prod(w, a1) + scaled(w1));
                in_one[c]   = round_word(prod(w, b2));
                loop_one[c] = round_word(prod(w, a2));
            end
            default: begin
                y = round_word(prod(x, b0) + scaled(x2));
                in_two[c] = round_word(prod(x, b1) + scaled(x1) + prod(y, a1));
                in_one[c] = round_word(prod(x, b2) + prod(y, a2));
            end
        endcase
        e.chan_out = it.chan;
        if (y > 32'sd8388607)
            e.sample_out = 24'sh7FFFFF;
        else if (y < -32'sd8388608)
            e.sample_out = 24'sh800000;
        else
            e.sample_out = y[23:0];
        expected_outputs.push_back(e);
    endfunction

    task report(string msg);
        errors++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_output(t_out_item got);
        t_out_item e;
        if (expected_outputs.size() == 0) begin
            report($sformatf("output chan %0d sample %0d with no sample pending",
                             got.chan_out, got.sample_out));
        end else begin
            e = expected_outputs.pop_front();
            if (got.sample_out !== e.sample_out)
                report($sformatf("chan %0d sample_out %0d, predicted %0d",
                                 e.chan_out, got.sample_out, e.sample_out));
            if (got.chan_out !== e.chan_out)
                report($sformatf("chan_out %0d, predicted %0d", got.chan_out, e.chan_out));
        end
    endtask

    function int pending();
        return expected_outputs.size();
    endfunction
endclass

module multichannel_biquad_four_forms_test;

    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_LIMIT    = 2000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    t_in_item    i_in_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = '0;
    logic [23:0] i_cfg_data = '0;

    biquad_checker sb;
    logic [23:0]   cfg_vals[8];
    bit            no_idle = 1'b0;
    int            items_sent = 0;
    int            idle_cycles = 0;

    multichannel_biquad_four_forms #(
        .NUM_CHANNELS(NUM_CH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic logic [23:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'h000000;
            3: return 24'h400000;
            default: return 24'hC00000;
        endcase
    endfunction

    function automatic logic [23:0] pick_coef(int style, bit is_a2);
        case (style)
            0, 1: begin
                // keeps the poles inside the unit circle so histories stay meaningful
                if (is_a2)
                    return 24'($urandom_range(0, 3145728) - 2097152);
                return 24'($urandom_range(0, 4194304) - 2097152);
            end
            2: return 24'($urandom());
            default: return pick_extreme();
        endcase
    endfunction

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return pick_extreme();
            1, 2, 3, 4: return 24'($urandom_range(0, 131072) - 65536);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic write_cfg(input logic [7:0] mask);
        for (int k = 0; k < 8; k++) begin
            if (mask[k]) begin
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= 3'(k);
                i_cfg_data <= cfg_vals[k];
                @(posedge i_clk);
                sb.write_reg(3'(k), cfg_vals[k]);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic [2:0] ch, input logic [23:0] smp);
        int gap;
        t_in_item it;
        gap = draw_gap();
        it.chan      = ch;
        it.sample_in = smp;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.accept_sample(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // history is written back as the result is registered, so this only idles after the last result
    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic pick_setting(output logic [7:0] mask);
        int style;
        style = $urandom_range(0, 3);
        mask  = '0;
        cfg_vals[CFG_MODE] = 24'($urandom());
        mask[CFG_MODE]     = ($urandom_range(0, 3) != 0);
        for (int k = CFG_B0; k <= CFG_A2; k++) begin
            cfg_vals[k] = pick_coef(style, k == CFG_A2);
            mask[k]     = ($urandom_range(0, 3) != 0);
        end
        cfg_vals[CFG_SPARE_LO] = 24'($urandom());
        cfg_vals[CFG_SPARE_HI] = 24'($urandom());
        mask[CFG_SPARE_LO]     = 1'($urandom_range(0, 1));
        mask[CFG_SPARE_HI]     = 1'($urandom_range(0, 1));
    endtask

    // output side: random stall before each result
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_output(o_out_data);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] mask;
        int n;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: transposed II, unity gain
        send_item(3'd0, 24'h7FFFFF);
        send_item(3'd7, 24'h800000);
        send_item(3'd3, 24'h000000);
        send_item(3'd5, 24'hFFFFFF);
        send_item(3'd1, 24'h000001);
        settle();

        // every form with extreme coefficients, saturating the histories
        cfg_vals[CFG_B0]       = 24'h7FFFFF;
        cfg_vals[CFG_B1]       = 24'h800000;
        cfg_vals[CFG_B2]       = 24'h7FFFFF;
        cfg_vals[CFG_A1]       = 24'h800000;
        cfg_vals[CFG_A2]       = 24'h7FFFFF;
        cfg_vals[CFG_SPARE_LO] = 24'hA5A5A5;
        cfg_vals[CFG_SPARE_HI] = 24'h5A5A5A;
        for (int m = 0; m < 4; m++) begin
            // upper bits of the mode word are don't-care
            cfg_vals[CFG_MODE] = (m == 0) ? 24'hFFFFFC : 24'(m);
            write_cfg((m == 0) ? 8'hFF : 8'h01);
            send_item(3'(2 * m), 24'h7FFFFF);
            send_item(3'(2 * m), 24'h7FFFFF);
            send_item(3'(2 * m), 24'h800000);
            send_item(3'd7, 24'h800000);
            settle();
        end

        // same mode again keeps history: zero coefficients expose the stored state
        cfg_vals[CFG_MODE] = 24'(MODE_DF2T);
        for (int k = CFG_B0; k <= CFG_A2; k++)
            cfg_vals[k] = '0;
        write_cfg(8'h3F);
        send_item(3'd6, 24'h123456);
        send_item(3'd6, 24'h000000);
        settle();

        while (items_sent < 1850) begin
            pick_setting(mask);
            write_cfg(mask);
            no_idle = ($urandom_range(0, 3) == 0);
            n = $urandom_range(60, 200);
            for (int i = 0; i < n; i++) begin
                // pause the sender until the block is empty
                if (i == n / 2)
                    wait_drained();
                send_item(3'($urandom_range(0, NUM_CH - 1)), pick_sample());
            end
            settle();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
sv/mbq4_pkg.sv
sv/mbq4_ram.sv
sv/multichannel_biquad_four_forms.sv
sv/mbq4_chk.sv
sim/multichannel_biquad_four_forms_test.sv
